[sv/rbo_pkg.sv]
// shared constants, types and sine table for the rotated box outline cell walker
`default_nettype none

package rbo_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int ADDR_W     = $clog2(MAX_CELLS);
  localparam int WIDTH_MAX  = 4096;
  localparam int MAPW_W     = 13;
  localparam int CSIZE_W    = 16;
  localparam int POS_W      = 24;
  localparam int HEAD_W     = 16;
  localparam int CELL_W     = 16;
  localparam int IDX_W      = 28;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = 40;
  localparam int TRIG_W     = 18;

  localparam logic [DIV_W-1:0] HALF_LEN_Q = 40'd40265318;
  localparam logic [DIV_W-1:0] HALF_WID_Q = 40'd30198989;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE = 1'b0,
    CFG_MAP_WIDTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] x;
    logic signed [CELL_W-1:0] y;
    logic [IDX_W-1:0]         key;
  } cell_ent_t;

  localparam int ENT_W = $bits(cell_ent_t);

  function automatic logic [16:0] sin_tab(input logic [4:0] i);
    case (i)
      5'd0:    return 17'd0;
      5'd1:    return 17'd6424;
      5'd2:    return 17'd12785;
      5'd3:    return 17'd19024;
      5'd4:    return 17'd25080;
      5'd5:    return 17'd30893;
      5'd6:    return 17'd36410;
      5'd7:    return 17'd41576;
      5'd8:    return 17'd46341;
      5'd9:    return 17'd50660;
      5'd10:   return 17'd54491;
      5'd11:   return 17'd57798;
      5'd12:   return 17'd60547;
      5'd13:   return 17'd62714;
      5'd14:   return 17'd64277;
      5'd15:   return 17'd65220;
      default: return 17'd65536;
    endcase
  endfunction

  function automatic logic [16:0] quarter_sine(input logic [14:0] a);
    logic [16:0] lo;
    logic [16:0] hi;
    logic [26:0] prod;
    lo   = sin_tab({1'b0, a[13:10]});
    hi   = sin_tab({1'b0, a[13:10]} + 5'd1);
    prod = {10'b0, 17'(hi - lo)} * {17'b0, a[9:0]};
    if (a >= 15'd16384) begin
      return 17'd65536;
    end
    return lo + prod[26:10];
  endfunction

  function automatic logic signed [TRIG_W-1:0] sine16(input logic [HEAD_W-1:0] h);
    logic [16:0] qa;
    logic [16:0] qb;
    qa = quarter_sine({1'b0, h[13:0]});
    qb = quarter_sine(15'd16384 - {1'b0, h[13:0]});
    case (h[15:14])
      2'd0:    return $signed({1'b0, qa});
      2'd1:    return $signed({1'b0, qb});
      2'd2:    return -$signed({1'b0, qa});
      default: return -$signed({1'b0, qb});
    endcase
  endfunction

endpackage

`default_nettype wire

[sv/rbo_ifs.sv]
// request channel interfaces for poses in and outline cells out
`default_nettype none

interface rbo_in_if;
  import rbo_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [HEAD_W-1:0]       heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface rbo_out_if;
  import rbo_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_x;
  logic signed [CELL_W-1:0] cell_y;
  logic signed [IDX_W-1:0]  cell_index;
  logic                     last;
  logic                     truncated;
  modport source (output valid, cell_x, cell_y, cell_index, last, truncated, input ready);
  modport sink (input valid, cell_x, cell_y, cell_index, last, truncated, output ready);
endinterface

`default_nettype wire

[sv/rbo_ram.sv]
// generic single write, single registered read port ram
`default_nettype none

module rbo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/rbo_div.sv]
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module rbo_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rbo_pkg::DIV_W-1:0]   num,
  input  wire logic [rbo_pkg::CSIZE_W-1:0] den,
  output logic                             done,
  output logic      [rbo_pkg::DIV_W-1:0]   quo
);
  import rbo_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]    quo_r;
  logic [DIV_W-1:0]    quo_nxt;
  logic [CSIZE_W-1:0]  rem_r;
  logic [CSIZE_W-1:0]  rem_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [CSIZE_W:0]    shifted;
  logic [CSIZE_W:0]    trial;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, den};
    if (shifted >= {1'b0, den}) begin
      rem_nxt = trial[CSIZE_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[CSIZE_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        rem_r  <= '0;
        cnt_r  <= CNT_BITS'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

[sv/rotated_box_outline_cells_unit.sv]
// top level: rotated box outline cell walker with dedup store and result streaming
// sequence: four serial divides, trig and corner setup, then per walked cell a dedup
// scan over the cells kept so far (one stored cell per cycle through the ram read
// port), then the kept cells are streamed out as results
// throughput: one pose at a time; a new pose is taken only once the last result is sent
// reset: cell_size 102, map_width 1024, sequencer idle and ready, no memory clearing
`default_nettype none

module rotated_box_outline_cells_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  rbo_in_if.sink                              in_ch,
  rbo_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [rbo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rbo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_TRIG, S_ROT, S_CSUM, S_CFIN,
    S_SETUP1, S_SETUP2, S_EIDX, S_SCAN, S_LTEST, S_MUL, S_DEC,
    S_ORD, S_OLD, S_OSEND
  } state_t;

  state_t state_r;

  logic [CSIZE_W-1:0]       cell_size_r;
  logic [MAPW_W-1:0]        map_width_r;
  logic [CSIZE_W-1:0]       cs_r;
  logic [MAPW_W-1:0]        mw_r;
  logic signed [POS_W-1:0]  pos_x_r;
  logic signed [POS_W-1:0]  pos_y_r;
  logic [HEAD_W-1:0]        head_r;
  logic [1:0]               div_k_r;
  logic signed [40:0]       cx_r;
  logic signed [40:0]       cy_r;
  logic [25:0]              hl_r;
  logic [25:0]              hw_r;
  logic signed [TRIG_W-1:0] s_r;
  logic signed [TRIG_W-1:0] c_r;
  logic [1:0]               rot_k_r;
  logic signed [44:0]       pa_r, pb_r, pc_r, pd_r;
  logic [2:0]               crn_r;
  logic signed [45:0]       sum_r;
  logic signed [31:0]       qx_r [4];
  logic signed [31:0]       qy_r [4];
  logic [1:0]               edge_r;
  logic [32:0]              atx_r, aty_r;
  logic                     stx_r, sty_r;
  logic signed [15:0]       endx_r, endy_r;
  logic signed [15:0]       walk_x_r, walk_y_r;
  logic signed [35:0]       crx_r, cry_r;
  logic [2:0]               mstep_r;
  logic signed [69:0]       accx_r, accy_r;
  logic [IDX_W-1:0]         key_r;
  logic [CNT_W-1:0]         scan_r;
  logic                     cmpv_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     cut_r;
  logic [CNT_W-1:0]         oi_r;
  logic                     ov_r;
  logic signed [CELL_W-1:0] ocx_r, ocy_r;
  logic [IDX_W-1:0]         oidx_r;
  logic                     olast_r, otrunc_r;

  // shared multiplier and helpers
  logic signed [26:0]       mul_a;
  logic signed [17:0]       mul_b;
  logic signed [44:0]       mul_p;
  logic signed [35:0]       m_cross;
  logic [32:0]              m_abs;
  logic [5:0]               m_sh;
  logic signed [69:0]       m_pp;
  logic [DIV_W-1:0]         div_num;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [POS_W-1:0]         pos_mag;
  logic                     pos_neg;
  logic                     pneg, qneg;
  logic signed [44:0]       t1, t2;
  logic signed [45:0]       adj;
  logic signed [41:0]       cvec;
  logic signed [31:0]       csat;
  logic signed [32:0]       tx, ty;
  logic signed [31:0]       fx_w, fy_w;
  logic signed [16:0]       dxs, dys;
  logic [16:0]              dx, dy;
  logic [17:0]              man;
  logic                     clx, cly;
  logic                     scan_end, dup, ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  cell_ent_t                ram_wdata, ram_rdata;

  function automatic logic signed [15:0] trunc_cell(input logic signed [31:0] v);
    logic signed [31:0] a;
    a = v + (v < 0 ? 32'sd65535 : 32'sd0);
    return a[31:16];
  endfunction

  always_comb begin
    pos_neg = (div_k_r == 2'd0) ? pos_x_r[POS_W-1] : pos_y_r[POS_W-1];
    pos_mag = (div_k_r == 2'd0) ? POS_W'(pos_neg ? -pos_x_r : pos_x_r)
                                : POS_W'(pos_neg ? -pos_y_r : pos_y_r);
    case (div_k_r)
      2'd0, 2'd1: div_num = {pos_mag, 16'b0};
      2'd2:       div_num = HALF_LEN_Q;
      default:    div_num = HALF_WID_Q;
    endcase
  end

  rbo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV_GO),
    .num   (div_num),
    .den   (cs_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    m_cross = mstep_r[2] ? cry_r : crx_r;
    m_abs   = mstep_r[2] ? atx_r : aty_r;
    m_sh    = (mstep_r[1] ? 6'd18 : 6'd0) + (mstep_r[0] ? 6'd17 : 6'd0);
    case (state_r)
      S_ROT: begin
        mul_a = $signed({1'b0, (rot_k_r[0] ? hw_r : hl_r)});
        case (rot_k_r)
          2'd0, 2'd3: mul_b = c_r;
          default:    mul_b = s_r;
        endcase
      end
      S_EIDX: begin
        mul_a = 27'(walk_y_r);
        mul_b = $signed({5'b0, mw_r});
      end
      S_MUL: begin
        mul_a = mstep_r[1] ? 27'($signed(m_cross[35:18])) : $signed({9'b0, m_cross[17:0]});
        mul_b = mstep_r[0] ? $signed({2'b0, m_abs[32:17]}) : $signed({1'b0, m_abs[16:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
    m_pp  = {{25{mul_p[44]}}, mul_p} <<< m_sh;
  end

  // corner arithmetic
  always_comb begin
    pneg = (crn_r[2:1] == 2'd0) || (crn_r[2:1] == 2'd1);
    qneg = (crn_r[2:1] == 2'd0) || (crn_r[2:1] == 2'd3);
    if (!crn_r[0]) begin
      t1 = pneg ? -pa_r : pa_r;
      t2 = qneg ? pb_r : -pb_r;
    end else begin
      t1 = pneg ? -pc_r : pc_r;
      t2 = qneg ? -pd_r : pd_r;
    end
    adj  = sum_r + (sum_r < 0 ? 46'sd65535 : 46'sd0);
    cvec = 42'($signed(adj[45:16])) + 42'(crn_r[0] ? cy_r : cx_r);
    if (cvec > 42'sd2147483647) begin
      csat = 32'sh7fffffff;
    end else if (cvec < -42'sd2147483648) begin
      csat = 32'sh80000000;
    end else begin
      csat = cvec[31:0];
    end
  end

  // walk setup and step rules
  always_comb begin
    tx   = 33'(qx_r[1]) - 33'(qx_r[0]);
    ty   = 33'(qy_r[1]) - 33'(qy_r[0]);
    fx_w = qx_r[0] - {walk_x_r, 16'b0};
    fy_w = qy_r[0] - {walk_y_r, 16'b0};
    dxs  = 17'(walk_x_r) - 17'(endx_r);
    dys  = 17'(walk_y_r) - 17'(endy_r);
    dx   = dxs[16] ? 17'(-dxs) : dxs;
    dy   = dys[16] ? 17'(-dys) : dys;
    man  = {1'b0, dx} + {1'b0, dy};
    clx  = stx_r ? (walk_x_r < endx_r) : (walk_x_r > endx_r);
    cly  = sty_r ? (walk_y_r < endy_r) : (walk_y_r > endy_r);
  end

  // dedup scan over the kept cells
  always_comb begin
    dup       = cmpv_r && (ram_rdata.key == key_r);
    scan_end  = (scan_r == cnt_r);
    ram_we    = (state_r == S_SCAN) && !dup && scan_end && (cnt_r != CNT_W'(MAX_CELLS));
    ram_raddr = (state_r == S_SCAN) ? scan_r[ADDR_W-1:0] : oi_r[ADDR_W-1:0];
    ram_wdata.x   = walk_x_r;
    ram_wdata.y   = walk_y_r;
    ram_wdata.key = key_r;
  end

  rbo_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cell_size_r <= 16'd102;
      map_width_r <= 13'd1024;
      div_k_r     <= '0;
      rot_k_r     <= '0;
      crn_r       <= '0;
      edge_r      <= '0;
      mstep_r     <= '0;
      scan_r      <= '0;
      cmpv_r      <= 1'b0;
      cnt_r       <= '0;
      cut_r       <= 1'b0;
      oi_r        <= '0;
      ov_r        <= 1'b0;
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      crx_r       <= '0;
      cry_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CELL_SIZE: cell_size_r <= cfg_data;
          CFG_MAP_WIDTH: map_width_r <= cfg_data[MAPW_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            pos_x_r <= in_ch.pos_x;
            pos_y_r <= in_ch.pos_y;
            head_r  <= in_ch.heading;
            cs_r    <= (cell_size_r == '0) ? CSIZE_W'(1) : cell_size_r;
            mw_r    <= (map_width_r > MAPW_W'(WIDTH_MAX)) ? MAPW_W'(WIDTH_MAX) : map_width_r;
            div_k_r <= '0;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            case (div_k_r)
              2'd0:    cx_r <= pos_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
              2'd1:    cy_r <= pos_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
              2'd2:    hl_r <= div_quo[25:0];
              default: hw_r <= div_quo[25:0];
            endcase
            div_k_r <= div_k_r + 2'd1;
            state_r <= (div_k_r == 2'd3) ? S_TRIG : S_DIV_GO;
          end
        end
        S_TRIG: begin
          s_r     <= sine16(head_r);
          c_r     <= sine16(head_r + 16'd16384);
          rot_k_r <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          case (rot_k_r)
            2'd0:    pa_r <= mul_p;
            2'd1:    pb_r <= mul_p;
            2'd2:    pc_r <= mul_p;
            default: pd_r <= mul_p;
          endcase
          rot_k_r <= rot_k_r + 2'd1;
          if (rot_k_r == 2'd3) begin
            crn_r   <= '0;
            state_r <= S_CSUM;
          end
        end
        S_CSUM: begin
          sum_r   <= 46'(t1) + 46'(t2);
          state_r <= S_CFIN;
        end
        S_CFIN: begin
          if (crn_r[0]) begin
            qy_r[crn_r[2:1]] <= csat;
          end else begin
            qx_r[crn_r[2:1]] <= csat;
          end
          crn_r <= crn_r + 3'd1;
          if (crn_r == 3'd7) begin
            edge_r  <= '0;
            cnt_r   <= '0;
            cut_r   <= 1'b0;
            state_r <= S_SETUP1;
          end else begin
            state_r <= S_CSUM;
          end
        end
        S_SETUP1: begin
          stx_r    <= !tx[32];
          sty_r    <= !ty[32];
          atx_r    <= tx[32] ? 33'(-tx) : 33'(tx);
          aty_r    <= ty[32] ? 33'(-ty) : 33'(ty);
          walk_x_r <= trunc_cell(qx_r[0]);
          walk_y_r <= trunc_cell(qy_r[0]);
          endx_r   <= trunc_cell(qx_r[1]);
          endy_r   <= trunc_cell(qy_r[1]);
          state_r  <= S_SETUP2;
        end
        S_SETUP2: begin
          crx_r   <= stx_r ? 36'sd65536 - 36'($signed(fx_w[16:0]))
                           : 36'($signed(fx_w[16:0]));
          cry_r   <= sty_r ? 36'sd65536 - 36'($signed(fy_w[16:0]))
                           : 36'($signed(fy_w[16:0]));
          state_r <= S_EIDX;
        end
        S_EIDX: begin
          key_r   <= IDX_W'(mul_p + 45'(walk_x_r));
          scan_r  <= '0;
          cmpv_r  <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (dup) begin
            state_r <= S_LTEST;
          end else if (scan_end) begin
            if (cnt_r == CNT_W'(MAX_CELLS)) begin
              cut_r   <= 1'b1;
              oi_r    <= '0;
              state_r <= S_ORD;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_LTEST;
            end
          end else begin
            scan_r <= scan_r + 1'b1;
            cmpv_r <= 1'b1;
          end
        end
        S_LTEST: begin
          if (walk_x_r == endx_r && walk_y_r == endy_r) begin
            if (edge_r == 2'd3) begin
              oi_r    <= '0;
              state_r <= S_ORD;
            end else begin
              edge_r  <= edge_r + 2'd1;
              qx_r    <= '{qx_r[1], qx_r[2], qx_r[3], qx_r[0]};
              qy_r    <= '{qy_r[1], qy_r[2], qy_r[3], qy_r[0]};
              state_r <= S_SETUP1;
            end
          end else begin
            mstep_r <= '0;
            accx_r  <= '0;
            accy_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mstep_r[2]) begin
            accy_r <= accy_r + m_pp;
          end else begin
            accx_r <= accx_r + m_pp;
          end
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r == 3'd7) begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          state_r <= S_EIDX;
          if (accx_r < accy_r && clx) begin
            crx_r    <= crx_r + 36'sd65536;
            walk_x_r <= walk_x_r + (stx_r ? 16'sd1 : -16'sd1);
          end else if (accy_r < accx_r && cly) begin
            cry_r    <= cry_r + 36'sd65536;
            walk_y_r <= walk_y_r + (sty_r ? 16'sd1 : -16'sd1);
          end else if (man <= 18'd2) begin
            if (dx > dy) begin
              walk_x_r <= walk_x_r + (stx_r ? 16'sd1 : -16'sd1);
            end else begin
              walk_y_r <= walk_y_r + (sty_r ? 16'sd1 : -16'sd1);
            end
          end else if (edge_r == 2'd3) begin
            oi_r    <= '0;
            state_r <= S_ORD;
          end else begin
            edge_r  <= edge_r + 2'd1;
            qx_r    <= '{qx_r[1], qx_r[2], qx_r[3], qx_r[0]};
            qy_r    <= '{qy_r[1], qy_r[2], qy_r[3], qy_r[0]};
            state_r <= S_SETUP1;
          end
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          ocx_r    <= ram_rdata.x;
          ocy_r    <= ram_rdata.y;
          oidx_r   <= ram_rdata.key;
          olast_r  <= (oi_r == CNT_W'(cnt_r - 1'b1));
          otrunc_r <= (oi_r == CNT_W'(cnt_r - 1'b1)) && cut_r;
          ov_r     <= 1'b1;
          state_r  <= S_OSEND;
        end
        S_OSEND: begin
          if (out_ch.ready) begin
            ov_r <= 1'b0;
            oi_r <= oi_r + 1'b1;
            state_r <= olast_r ? S_IDLE : S_ORD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.cell_x     = ocx_r;
  assign out_ch.cell_y     = ocy_r;
  assign out_ch.cell_index = $signed(oidx_r);
  assign out_ch.last       = olast_r;
  assign out_ch.truncated  = otrunc_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CELLS))
    else $error("kept cell count beyond limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= cnt_r))
    else $error("dedup scan ran past kept cells");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("result pending while taking a new request");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.truncated) |-> out_ch.last)
    else $error("truncated flag on a non-final result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("not ready after final result");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// testbench for the rotated box outline cell walker: scoreboard against an in-bench predictor
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbo_pkg::*;

  typedef struct {
    logic signed [CELL_W-1:0] x;
    logic signed [CELL_W-1:0] y;
    logic [IDX_W-1:0]         key;
    logic                     last;
    logic                     truncated;
  } outline_cell_t;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [HEAD_W-1:0]       hd;
  } pose_t;

  typedef struct {
    int unsigned csize;
    int unsigned mapw;
    int          count;
    int          mode;
  } phase_t;

  localparam int Q16 = 65536;
  localparam int SINE_PTS[17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
                                  50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CELL_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rbo_in_if in_ch ();
  rbo_out_if out_ch ();

  rotated_box_outline_cells_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  pose_t         poses_pending[$];
  outline_cell_t cells_due[$];
  logic [IDX_W-1:0] pose_keys[$];
  bit            pose_cut;
  int unsigned   grid_csize = 102;
  int unsigned   grid_mapw = 1024;
  int            send_idle = 0;
  int            recv_stall = 0;
  int            errors = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int quarter_wave(input int a);
    int i;
    int f;
    if (a >= 16384) return Q16;
    i = a >> 10;
    f = a & 1023;
    return SINE_PTS[i] + (((SINE_PTS[i+1] - SINE_PTS[i]) * f) >>> 10);
  endfunction

  function automatic int heading_sine(input logic [15:0] h);
    int a;
    a = int'(h[13:0]);
    case (h[15:14])
      2'd0:    return quarter_wave(a);
      2'd1:    return quarter_wave(16384 - a);
      2'd2:    return -quarter_wave(a);
      default: return -quarter_wave(16384 - a);
    endcase
  endfunction

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int abs32(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit add_cell(input int x, input int y);
    longint w;
    longint idx;
    logic [IDX_W-1:0] key;
    outline_cell_t c;
    w = grid_mapw > WIDTH_MAX ? WIDTH_MAX : grid_mapw;
    idx = longint'(y) * w + longint'(x);
    key = idx[IDX_W-1:0];
    foreach (pose_keys[i]) if (pose_keys[i] == key) return 1'b1;
    if (pose_keys.size() >= MAX_CELLS) begin
      pose_cut = 1'b1;
      return 1'b0;
    end
    pose_keys.push_back(key);
    c.x = x[15:0];
    c.y = y[15:0];
    c.key = key;
    c.last = 1'b0;
    c.truncated = 1'b0;
    cells_due.push_back(c);
    return 1'b1;
  endfunction

  function automatic bit trace_edge(input int sx, input int sy, input int ex, input int ey);
    longint tx, ty, atx, aty, crx, cry, kx, ky;
    int stx, sty, endx, endy, wx, wy, fx, fy, dx, dy;
    tx = longint'(ex) - sx;
    ty = longint'(ey) - sy;
    stx = tx >= 0 ? 1 : -1;
    sty = ty >= 0 ? 1 : -1;
    atx = tx < 0 ? -tx : tx;
    aty = ty < 0 ? -ty : ty;
    endx = ex / Q16;
    endy = ey / Q16;
    wx = sx / Q16;
    wy = sy / Q16;
    if (!add_cell(wx, wy)) return 1'b0;
    fx = sx - wx * Q16;
    fy = sy - wy * Q16;
    crx = stx > 0 ? longint'(Q16 - fx) : longint'(fx);
    cry = sty > 0 ? longint'(Q16 - fy) : longint'(fy);
    while (wx != endx || wy != endy) begin
      kx = crx * aty;
      ky = cry * atx;
      dx = abs32(wx - endx);
      dy = abs32(wy - endy);
      if (kx < ky && abs32(wx + stx - endx) < dx) begin
        crx += Q16;
        wx += stx;
      end else if (ky < kx && abs32(wy + sty - endy) < dy) begin
        cry += Q16;
        wy += sty;
      end else if (dx + dy <= 2) begin
        if (dx > dy) wx += stx;
        else wy += sty;
      end else begin
        break;
      end
      if (!add_cell(wx, wy)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_outline(input pose_t p);
    longint cs, ctrx, ctry, sn, cn, hl, hw;
    longint ox[4], oy[4];
    int qx[4], qy[4];
    int n;
    cs = grid_csize == 0 ? 1 : longint'(grid_csize);
    ctrx = longint'(p.px) * Q16 / cs;
    ctry = longint'(p.py) * Q16 / cs;
    sn = heading_sine(p.hd);
    cn = heading_sine(p.hd + 16'd16384);
    hl = 40265318 / cs;
    hw = 30198989 / cs;
    ox = '{-hl, -hl, hl, hl};
    oy = '{-hw, hw, hw, -hw};
    for (int k = 0; k < 4; k++) begin
      qx[k] = clamp32((ox[k] * cn - oy[k] * sn) / Q16 + ctrx);
      qy[k] = clamp32((ox[k] * sn + oy[k] * cn) / Q16 + ctry);
    end
    pose_keys.delete();
    pose_cut = 1'b0;
    n = cells_due.size();
    for (int k = 0; k < 4; k++)
      if (!trace_edge(qx[k], qy[k], qx[(k + 1) % 4], qy[(k + 1) % 4])) break;
    if (cells_due.size() > n) begin
      cells_due[cells_due.size() - 1].last = 1'b1;
      cells_due[cells_due.size() - 1].truncated = pose_cut;
    end
  endfunction

  // request driver and result ready
  always @(posedge clk) begin
    pose_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        if (poses_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          p = poses_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.pos_x <= p.px;
          in_ch.pos_y <= p.py;
          in_ch.heading <= p.hd;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= $urandom_range(99) >= recv_stall;
    end
  end

  always @(posedge clk) begin
    pose_t p;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.px = in_ch.pos_x;
      p.py = in_ch.pos_y;
      p.hd = in_ch.heading;
      predict_outline(p);
    end
  end

  // result monitor
  always @(posedge clk) begin
    outline_cell_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cells_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = cells_due.pop_front();
        if (out_ch.cell_x !== e.x)
          report($sformatf("cell_x %0d expected %0d", out_ch.cell_x, e.x));
        if (out_ch.cell_y !== e.y)
          report($sformatf("cell_y %0d expected %0d", out_ch.cell_y, e.y));
        if (out_ch.cell_index !== e.key)
          report($sformatf("cell_index %0h expected %0h", out_ch.cell_index, e.key));
        if (out_ch.last !== e.last)
          report($sformatf("last %0b expected %0b", out_ch.last, e.last));
        if (out_ch.truncated !== e.truncated)
          report($sformatf("truncated %0b expected %0b", out_ch.truncated, e.truncated));
      end
    end
  end

  task automatic write_reg(input cfg_reg_t r, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == CFG_CELL_SIZE) grid_csize = v & 16'hffff;
    else grid_mapw = v & 13'h1fff;
  endtask

  task automatic wait_drained();
    while (poses_pending.size() > 0 || cells_due.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void queue_pose(input int x, input int y, input int h);
    pose_t p;
    p.px = x[POS_W-1:0];
    p.py = y[POS_W-1:0];
    p.hd = h[HEAD_W-1:0];
    poses_pending.push_back(p);
  endfunction

  function automatic int rand_pos();
    if ($urandom_range(9) < 7) return int'($urandom_range(400000)) - 200000;
    return int'($urandom_range(24'hffffff)) - 8388608;
  endfunction

  initial begin
    phase_t plan[9];
    int heads[6];
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.heading = '0;
    out_ch.ready = 1'b0;
    plan = '{'{102, 1024, 0, 0}, '{102, 1024, 80, 1}, '{1, 4096, 20, 2},
             '{65535, 8191, 40, 3}, '{0, 4097, 20, 0}, '{300, 0, 60, 1},
             '{250, 1, 60, 2}, '{51, 37, 80, 3}, '{1000, 100, 75, 0}};
    heads = '{0, 16383, 16384, 32768, 49152, 65535};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner poses, quadrant headings and sign boundaries under reset settings
    foreach (heads[i]) queue_pose(0, 0, heads[i]);
    queue_pose(8388607, 8388607, 0);
    queue_pose(-8388608, -8388608, 16384);
    queue_pose(8388607, -8388608, 1024);
    queue_pose(-8388608, 8388607, 40000);
    queue_pose(-1, -1, 8192);
    queue_pose(1, 1, 24576);
    queue_pose(-50, 30, 1023);
    queue_pose(101, -101, 1025);
    queue_pose(102, 102, 57344);
    queue_pose(-5000, 7000, 12345);
    queue_pose(2000000, -2000000, 65000);
    queue_pose(-3000000, 3000000, 33000);
    queue_pose(-55, -55, 49151);
    queue_pose(int'(24'h555555), -int'(24'h2aaaaa), 16'haaaa);
    queue_pose(-int'(24'h555555), int'(24'h2aaaaa), 16'h5555);
    queue_pose(0, 8388607, 32767);
    wait_drained();

    foreach (plan[ph]) begin
      if (ph == 0) continue;
      write_reg(CFG_CELL_SIZE, plan[ph].csize);
      write_reg(CFG_MAP_WIDTH, plan[ph].mapw);
      case (plan[ph].mode)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 79; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      for (int n = 0; n < plan[ph].count; n++)
        queue_pose(rand_pos(), rand_pos(), int'($urandom_range(65535)));
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
